// File: sv/sukt_pkg.sv
// ----------------------------------------------------------------------------
// sukt_pkg
// Shared types and constants for the sorted unique key table.
// ----------------------------------------------------------------------------
package sukt_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int KEY_W = 32;
	localparam int VAL_W = 16;
	localparam int RIDX_W = 6;
	localparam int POS_W = 7;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_READ   = 2'd2,
		OP_UNDEF  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_DUP      = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_RANGE    = 3'd4
	} status_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             kind;
		logic [VAL_W-1:0] value;
	} entry_t;

endpackage

// File: sv/sukt_if.sv
// ----------------------------------------------------------------------------
// sukt request and result channels
// Valid/ready channels carrying one request or one result.
// ----------------------------------------------------------------------------
interface sukt_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  operation;
	logic [31:0] part_key;
	logic        entry_kind;
	logic [15:0] entry_value;
	logic [5:0]  read_index;

	modport source (output valid, operation, part_key, entry_kind, entry_value, read_index,
		input ready);
	modport sink (input valid, operation, part_key, entry_kind, entry_value, read_index,
		output ready);
endinterface

interface sukt_res_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [6:0]  position;
	logic [31:0] found_key;
	logic        found_kind;
	logic [15:0] found_value;
	logic [6:0]  entry_count;

	modport source (output valid, status, position, found_key, found_kind, found_value,
		entry_count, input ready);
	modport sink (input valid, status, position, found_key, found_kind, found_value,
		entry_count, output ready);
endinterface

// File: sv/sukt_mem.sv
// ----------------------------------------------------------------------------
// sukt_mem
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module sukt_mem (
	input  logic                  clk,
	input  logic                  rd_en,
	input  logic [sukt_pkg::IDX_W-1:0] rd_addr,
	output sukt_pkg::entry_t      rd_data,
	input  logic                  wr_en,
	input  logic [sukt_pkg::IDX_W-1:0] wr_addr,
	input  sukt_pkg::entry_t      wr_data
);
	import sukt_pkg::*;

	entry_t mem [TABLE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: sv/sorted_unique_key_table.sv
// ----------------------------------------------------------------------------
// sorted_unique_key_table
// Table of unique keys kept in ascending order, with insert, find and read.
// ----------------------------------------------------------------------------
//  Channel  Direction  Carries
//  req      in         operation, key, kind, value, read index
//  res      out        status, position, entry fields, entry count
//
// Insert and find run a binary search, one store read per probe, with at most
// ceil(log2(count+1)) probes; a new insert then moves each larger entry up by
// one, reading it and writing it back, and finally writes the new entry. An
// in-range read reads the store once; any other request needs no store access.
// Reset empties the table; the store itself is not cleared.
// A new request is taken while a result still waits; its own result then
// stalls until the waiting one has been taken.
module sorted_unique_key_table (
	input  logic       clk,
	input  logic       arst_n,
	sukt_req_if.sink   req,
	sukt_res_if.source res
);
	import sukt_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SEARCH, S_PROBE, S_DECIDE, S_SHIFT, S_SHIFT_WR, S_READ, S_FINISH
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [CNT_W-1:0]   j_q;
	logic [CNT_W-1:0]   mid_q;
	logic               hit_q;
	entry_t             hit_data_q;
	op_t                op_q;
	entry_t             new_q;
	status_t            res_status_q;
	logic [POS_W-1:0]   res_pos_q;
	entry_t             res_data_q;
	logic               out_valid_q;

	logic               rd_en;
	logic [IDX_W-1:0]   rd_addr;
	entry_t             rd_data;
	logic               wr_en;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             wr_data;
	logic [CNT_W:0]     mid_sum;
	logic [CNT_W-1:0]   mid;
	logic               accept;
	logic [CNT_W-1:0]   ridx_ext;

	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid = mid_sum[CNT_W:1];
	assign ridx_ext = CNT_W'(req.read_index);

	sukt_mem u_mem (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	always_comb begin
		rd_en = 1'b0;
		rd_addr = '0;
		wr_en = 1'b0;
		wr_addr = '0;
		wr_data = new_q;
		unique case (state_q)
			S_IDLE: begin
				rd_en = accept && (op_t'(req.operation) == OP_READ) && (ridx_ext < count_q);
				rd_addr = IDX_W'(req.read_index);
			end
			S_SEARCH: begin
				rd_en = (lo_q < hi_q);
				rd_addr = mid[IDX_W-1:0];
			end
			S_SHIFT: begin
				if (j_q > lo_q) begin
					rd_en = 1'b1;
					rd_addr = IDX_W'(j_q - CNT_W'(1));
				end else begin
					wr_en = 1'b1;
					wr_addr = lo_q[IDX_W-1:0];
				end
			end
			S_SHIFT_WR: begin
				wr_en = 1'b1;
				wr_addr = j_q[IDX_W-1:0];
				wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_FINISH) && (!out_valid_q || res.ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q <= op_t'(req.operation);
						new_q <= '{key: req.part_key, kind: req.entry_kind,
							value: req.entry_value};
						lo_q <= '0;
						hi_q <= count_q;
						hit_q <= 1'b0;
						res_data_q <= '0;
						unique case (op_t'(req.operation))
							OP_INSERT, OP_FIND: begin
								state_q <= S_SEARCH;
							end
							OP_READ: begin
								res_pos_q <= POS_W'(req.read_index);
								if (ridx_ext < count_q) begin
									res_status_q <= ST_OK;
									state_q <= S_READ;
								end else begin
									res_status_q <= ST_RANGE;
									state_q <= S_FINISH;
								end
							end
							OP_UNDEF: begin
								res_status_q <= ST_RANGE;
								res_pos_q <= POS_W'(count_q);
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SEARCH: begin
					mid_q <= mid;
					state_q <= (lo_q < hi_q) ? S_PROBE : S_DECIDE;
				end
				S_PROBE: begin
					if (rd_data.key < new_q.key) begin
						lo_q <= mid_q + CNT_W'(1);
					end else begin
						hi_q <= mid_q;
						if (rd_data.key == new_q.key) begin
							hit_q <= 1'b1;
							hit_data_q <= rd_data;
						end
					end
					state_q <= S_SEARCH;
				end
				S_DECIDE: begin
					if (hit_q) begin
						res_status_q <= (op_q == OP_INSERT) ? ST_DUP : ST_OK;
						res_pos_q <= POS_W'(lo_q);
						res_data_q <= hit_data_q;
						state_q <= S_FINISH;
					end else if (op_q == OP_FIND) begin
						res_status_q <= ST_NOTFOUND;
						res_pos_q <= POS_W'(count_q);
						state_q <= S_FINISH;
					end else if (count_q == CNT_W'(TABLE_DEPTH)) begin
						res_status_q <= ST_FULL;
						res_pos_q <= POS_W'(count_q);
						state_q <= S_FINISH;
					end else begin
						j_q <= count_q;
						state_q <= S_SHIFT;
					end
				end
				S_SHIFT: begin
					if (j_q > lo_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						count_q <= count_q + CNT_W'(1);
						res_status_q <= ST_OK;
						res_pos_q <= POS_W'(lo_q);
						res_data_q <= new_q;
						state_q <= S_FINISH;
					end
				end
				S_SHIFT_WR: begin
					j_q <= j_q - CNT_W'(1);
					state_q <= S_SHIFT;
				end
				S_READ: begin
					res_data_q <= rd_data;
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!out_valid_q || res.ready) begin
						res.status <= res_status_q;
						res.position <= res_pos_q;
						res.found_key <= res_data_q.key;
						res.found_kind <= res_data_q.kind;
						res.found_value <= res_data_q.value;
						res.entry_count <= POS_W'(count_q);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res.valid = out_valid_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("entry count exceeds table depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("entry count changed by other than one");

	a_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == S_SHIFT || state_q == S_SHIFT_WR))
		else $error("store written outside an insert");

	a_search_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SEARCH) |-> (lo_q <= hi_q))
		else $error("search bounds crossed");

endmodule

// File: dv/sukt_checker.sv
// ----------------------------------------------------------------------------
// sukt_checker
// Watches the request and result channels of the sorted unique key table,
// keeps its own ordered copy of the table, predicts each result and compares
// it field by field with what the block returns.
// ----------------------------------------------------------------------------
module sukt_checker
	import sukt_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	sukt_req_if    req,
	sukt_res_if    res,
	output int     fail_count,
	output int     pending
);

	typedef struct {
		status_t          status;
		logic [POS_W-1:0] position;
		entry_t           entry;
		logic [POS_W-1:0] count;
	} answer_t;

	entry_t    table_copy [TABLE_DEPTH];
	int        held;
	answer_t   awaited [$];

	function automatic int first_not_below(logic [KEY_W-1:0] key);
		int i;
		i = 0;
		while (i < held && table_copy[i].key < key)
			i++;
		return i;
	endfunction

	task automatic predict_answer(op_t op, logic [KEY_W-1:0] key, logic kind,
		logic [VAL_W-1:0] value, logic [RIDX_W-1:0] idx);
		answer_t a;
		int slot;
		a.entry = '0;
		case (op)
			OP_INSERT, OP_FIND: begin
				slot = first_not_below(key);
				if (slot < held && table_copy[slot].key == key) begin
					a.status = (op == OP_INSERT) ? ST_DUP : ST_OK;
					a.position = POS_W'(slot);
					a.entry = table_copy[slot];
				end else if (op == OP_FIND) begin
					a.status = ST_NOTFOUND;
					a.position = POS_W'(held);
				end else if (held >= TABLE_DEPTH) begin
					a.status = ST_FULL;
					a.position = POS_W'(held);
				end else begin
					for (int j = held; j > slot; j--)
						table_copy[j] = table_copy[j-1];
					table_copy[slot] = '{key: key, kind: kind, value: value};
					held++;
					a.status = ST_OK;
					a.position = POS_W'(slot);
					a.entry = table_copy[slot];
				end
			end
			OP_READ: begin
				a.position = POS_W'(idx);
				if (int'(idx) < held) begin
					a.status = ST_OK;
					a.entry = table_copy[idx];
				end else begin
					a.status = ST_RANGE;
				end
			end
			default: begin
				a.status = ST_RANGE;
				a.position = POS_W'(held);
			end
		endcase
		a.count = POS_W'(held);
		awaited.push_back(a);
	endtask

	assign pending = awaited.size();

	always @(posedge clk or negedge arst_n) begin
		answer_t a;
		if (!arst_n) begin
			held = 0;
			fail_count = 0;
			awaited.delete();
		end else begin
			if (res.valid && res.ready) begin
				if (awaited.size() == 0) begin
					$error("result with no request outstanding");
					fail_count++;
				end else begin
					a = awaited.pop_front();
					if (res.status !== a.status) begin
						$error("status expected %0d actual %0d", a.status, res.status);
						fail_count++;
					end
					if (res.position !== a.position) begin
						$error("position expected %0d actual %0d", a.position, res.position);
						fail_count++;
					end
					if (res.found_key !== a.entry.key) begin
						$error("found_key expected %h actual %h", a.entry.key, res.found_key);
						fail_count++;
					end
					if (res.found_kind !== a.entry.kind) begin
						$error("found_kind expected %0d actual %0d", a.entry.kind,
							res.found_kind);
						fail_count++;
					end
					if (res.found_value !== a.entry.value) begin
						$error("found_value expected %h actual %h", a.entry.value,
							res.found_value);
						fail_count++;
					end
					if (res.entry_count !== a.count) begin
						$error("entry_count expected %0d actual %0d", a.count,
							res.entry_count);
						fail_count++;
					end
				end
			end
			if (req.valid && req.ready)
				predict_answer(op_t'(req.operation), req.part_key, req.entry_kind,
					req.entry_value, req.read_index);
		end
	end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives requests into the sorted unique key table with random idling on
// both channels, including a long hold-off on results, and reports the
// verdict from the checker's failure and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
	import sukt_pkg::*;

	localparam int STALL_LIMIT = 20000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   send_idle_pct;
	int   take_idle_pct;
	bit   hold_results;
	bit   stimulus_done;
	int   quiet_cycles;
	logic [KEY_W-1:0] known_keys [$];

	sukt_req_if req ();
	sukt_res_if res ();

	sorted_unique_key_table uut (.clk(clk), .arst_n(arst_n), .req(req), .res(res));
	sukt_checker checker_i (.clk(clk), .arst_n(arst_n), .req(req), .res(res),
		.fail_count(fail_count), .pending(pending));

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (!arst_n || hold_results)
			res.ready <= 1'b0;
		else
			res.ready <= ($urandom_range(99) >= take_idle_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (req.valid && req.ready) || (res.valid && res.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic send(op_t op, logic [KEY_W-1:0] key, logic kind, logic [VAL_W-1:0] value,
		logic [RIDX_W-1:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid <= 1'b1;
		req.operation <= op;
		req.part_key <= key;
		req.entry_kind <= kind;
		req.entry_value <= value;
		req.read_index <= idx;
		if (op == OP_INSERT)
			known_keys.push_back(key);
		do
			@(posedge clk);
		while (!req.ready);
	endtask

	task automatic send_random(bit narrow);
		int pick;
		logic [KEY_W-1:0] key;
		pick = $urandom_range(99);
		key = narrow ? KEY_W'($urandom_range(200)) : $urandom;
		if (known_keys.size() > 0 && $urandom_range(2) == 0)
			key = known_keys[$urandom_range(known_keys.size() - 1)];
		if (pick < 40)
			send(OP_INSERT, key, 1'($urandom_range(1)), VAL_W'($urandom_range(65535)),
				RIDX_W'($urandom));
		else if (pick < 70)
			send(OP_FIND, key, 1'($urandom_range(1)), VAL_W'($urandom), RIDX_W'($urandom));
		else if (pick < 97)
			send(OP_READ, $urandom, 1'($urandom_range(1)), VAL_W'($urandom),
				RIDX_W'($urandom_range(63)));
		else
			send(OP_UNDEF, $urandom, 1'($urandom_range(1)), VAL_W'($urandom),
				RIDX_W'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.operation = OP_INSERT;
		req.part_key = '0;
		req.entry_kind = 1'b0;
		req.entry_value = '0;
		req.read_index = '0;
		send_idle_pct = 13;
		take_idle_pct = 52;
		hold_results = 1'b0;
		stimulus_done = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send(OP_READ, '0, 1'b0, '0, 6'd0);
		send(OP_FIND, 32'hFFFF_FFFF, 1'b0, '0, '0);
		send(OP_INSERT, 32'hFFFF_FFFF, 1'b1, 16'hFFFF, 6'h3F);
		send(OP_INSERT, 32'h0000_0000, 1'b0, 16'h0000, '0);
		send(OP_INSERT, 32'h8000_0000, 1'b1, 16'h5A5A, '0);
		send(OP_INSERT, 32'hFFFF_FFFF, 1'b0, 16'h1234, '0);
		send(OP_FIND, 32'h0000_0000, 1'b0, '0, '0);
		send(OP_FIND, 32'h8000_0001, 1'b0, '0, '0);
		send(OP_READ, '0, 1'b0, '0, 6'd2);
		send(OP_READ, '0, 1'b0, '0, 6'd3);
		send(OP_READ, '0, 1'b0, '0, 6'h3F);
		send(OP_UNDEF, 32'hA5A5_A5A5, 1'b1, 16'hFFFF, 6'h3F);

		// Fill the table to capacity, then probe full and duplicate handling.
		for (int k = 0; k < TABLE_DEPTH; k++)
			send(OP_INSERT, KEY_W'(32'h0001_0000 * k + 5), k[0],
				VAL_W'($urandom_range(65535)), '0);
		send(OP_INSERT, 32'h7777_7777, 1'b1, 16'hBEEF, '0);
		send(OP_INSERT, 32'h8000_0000, 1'b0, 16'h0001, '0);
		send(OP_READ, '0, 1'b0, '0, 6'h3F);
		send(OP_FIND, 32'hFFFF_FFFF, 1'b0, '0, '0);

		// The table cannot drain, and a restart from an empty state is not possible
		// without reset, so the rest keeps exercising a full table via reads, finds
		// and inserts, alternating the narrow key range with the full one.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 13 : (phase == 1) ? 52 : 0;
			take_idle_pct = (phase == 0) ? 52 : (phase == 1) ? 13 : 0;
			for (int n = 0; n < 413; n++)
				send_random(n % 2 == 0);
		end

		// Long hold-off on results while requests keep coming.
		fork
			begin
				hold_results = 1'b1;
				repeat (300) @(posedge clk);
				hold_results = 1'b0;
			end
			for (int n = 0; n < 30; n++)
				send_random(1'b1);
		join
		req.valid <= 1'b0;

		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
